// ----- src/sdp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_pkg: shared definitions of the step/direction pulse generator
// Timer constants, derived widths, command codes and divider handshake types.
// ----------------------------------------------------------------------------
package sdp_pkg;

   // timer setup
   localparam int TIMER_CLOCK_HZ = 8000000;
   localparam int PRESCALE       = 8;
   localparam int MIN_FREQ       = 100;
   localparam int MAX_FREQ       = 5000;
   localparam int DEFAULT_FREQ   = 500;

   // word field widths
   localparam int CMD_W   = 2;
   localparam int COUNT_W = 32;
   localparam int HZ_W    = 32;

   // internal widths
   localparam int PRESCALE_W = 3;
   localparam int PERIOD_W   = 16;
   localparam int FREQ_W     = $clog2(MAX_FREQ + 1);
   localparam int DIVIDEND_W = $clog2(TIMER_CLOCK_HZ + 1);
   localparam int DIVISOR_W  = $clog2(MAX_FREQ * PRESCALE + 1);
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

   // reload after reset, worked out at elaboration
   localparam int DEFAULT_CLAMPED = (DEFAULT_FREQ < MIN_FREQ) ? MIN_FREQ :
                                    (DEFAULT_FREQ > MAX_FREQ) ? MAX_FREQ : DEFAULT_FREQ;
   localparam int DEFAULT_QUOT    = (TIMER_CLOCK_HZ / DEFAULT_CLAMPED) / PRESCALE;
   localparam logic [PERIOD_W-1:0] DEFAULT_RELOAD =
      (DEFAULT_QUOT == 0)     ? '0 :
      (DEFAULT_QUOT > 65536)  ? '1 : PERIOD_W'(DEFAULT_QUOT - 1);

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK     = 2'd0,
      CMD_START    = 2'd1,
      CMD_STOP     = 2'd2,
      CMD_SET_FREQ = 2'd3
   } cmd_type;

   // divider control and status
   typedef struct packed {
      logic                 start;
      logic [DIVISOR_W-1:0] divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- src/sdp_channels.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_channels: valid/ready channels of the pulse generator
// Command word channel and status word channel.
// ----------------------------------------------------------------------------
interface sdp_req_if;
   import sdp_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [COUNT_W-1:0] steps;
   logic              direction;
   logic [HZ_W-1:0]   freq_hz;

   modport source (output valid, cmd, steps, direction, freq_hz, input ready);
   modport sink   (input valid, cmd, steps, direction, freq_hz, output ready);
endinterface

interface sdp_rsp_if;
   import sdp_pkg::*;

   logic               valid;
   logic               ready;
   logic               pulse_level;
   logic               dir_level;
   logic               busy_res;
   logic               step_event;
   logic [COUNT_W-1:0] steps_done;

   modport source (output valid, pulse_level, dir_level, busy_res, step_event, steps_done,
                   input ready);
   modport sink   (input valid, pulse_level, dir_level, busy_res, step_event, steps_done,
                   output ready);
endinterface

// ----- src/sdp_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_divider: serial restoring divider for the period reload
// Divides the timer clock by a registered divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module sdp_divider (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sdp_pkg::div_ctrl_type                 ctrl,
   output sdp_pkg::div_stat_type                 stat,
   output logic [sdp_pkg::DIVIDEND_W-1:0]        quotient
);
   import sdp_pkg::*;

   localparam logic [DIVIDEND_W-1:0] DIVIDEND = DIVIDEND_W'(TIMER_CLOCK_HZ);
   localparam logic [DIV_CNT_W-1:0]  LAST_BIT = DIV_CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    shifted;
   logic                  fits;

   // shift in the next dividend bit and trial-subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits    = shifted >= {1'b0, divisor_ff};
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      if (ctrl.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         divisor_in = ctrl.divisor;
         rem_in     = '0;
         quo_in     = DIVIDEND;
      end else if (busy_ff) begin
         rem_in   = fits ? DIVISOR_W'(shifted - {1'b0, divisor_ff}) : shifted[DIVISOR_W-1:0];
         quo_in   = {quo_ff[DIVIDEND_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_BIT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

// ----- src/step_dir_pulse_generator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_dir_pulse_generator_unit: step/direction pulse generator
// Runs the step timer on tick words and handles start, stop and frequency
// words; one status word goes out for every command word.
//
//   channel   dir  word contents
//   req       in   cmd, steps, direction, freq_hz
//   rsp       out  pulse_level, dir_level, busy_res, step_event, steps_done
//
// Tick, start and stop words are taken back to back while the status
// register drains. A set-frequency word waits in ST_DIVIDE while the
// serial divider makes one quotient bit a cycle, and req is held low
// meanwhile. Reset is synchronous and loads the default reload; a stalled
// rsp holds req low until taken.
// ----------------------------------------------------------------------------
module step_dir_pulse_generator_unit (
   input  logic      clock,
   input  logic      reset,
   sdp_req_if.sink   req_channel,
   sdp_rsp_if.source rsp_channel
);
   import sdp_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_DIVIDE
   } state_type;

   localparam logic [PRESCALE_W:0] PRESCALE_END = (PRESCALE_W + 1)'(PRESCALE);

   state_type             state_ff, state_in;
   logic                  running_ff, running_in;
   logic [COUNT_W-1:0]    sent_ff, sent_in;
   logic [COUNT_W-1:0]    target_ff, target_in;
   logic                  dir_ff, dir_in;
   logic                  pulse_ff, pulse_in;
   logic [PRESCALE_W-1:0] prescale_ff, prescale_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [PERIOD_W-1:0]   reload_ff, reload_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  event_ff, event_in;

   logic                  req_fire;
   logic [FREQ_W-1:0]     hz_clamp;
   logic [COUNT_W-1:0]    sent_next;
   logic [PERIOD_W-1:0]   period_next;
   logic [PERIOD_W-1:0]   reload_q;
   div_ctrl_type          div_ctrl;
   div_stat_type          div_stat;
   logic [DIVIDEND_W-1:0] div_quot;

   sdp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   // take a word when idle and the status slot is free or draining
   assign req_channel.ready = (state_ff == ST_IDLE) && !div_stat.busy &&
                              (!rsp_valid_ff || rsp_channel.ready);
   assign req_fire = req_channel.valid && req_channel.ready;

   // clamp the requested rate to the limits
   always_comb begin
      if (req_channel.freq_hz < HZ_W'(MIN_FREQ)) begin
         hz_clamp = FREQ_W'(MIN_FREQ);
      end else if (req_channel.freq_hz > HZ_W'(MAX_FREQ)) begin
         hz_clamp = FREQ_W'(MAX_FREQ);
      end else begin
         hz_clamp = req_channel.freq_hz[FREQ_W-1:0];
      end
   end

   // saturate the quotient into a reload value
   always_comb begin
      if (div_quot == '0) begin
         reload_q = '0;
      end else if (div_quot > DIVIDEND_W'(65536)) begin
         reload_q = '1;
      end else begin
         reload_q = PERIOD_W'(div_quot - 1'b1);
      end
   end

   assign period_next = (period_ff == reload_ff) ? '0 : period_ff + 1'b1;
   assign sent_next   = sent_ff + 1'b1;

   // sequence the command words
   always_comb begin
      state_in     = state_ff;
      running_in   = running_ff;
      sent_in      = sent_ff;
      target_in    = target_ff;
      dir_in       = dir_ff;
      pulse_in     = pulse_ff;
      prescale_in  = prescale_ff;
      period_in    = period_ff;
      reload_in    = reload_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_channel.ready;
      event_in     = event_ff;
      div_ctrl.start   = 1'b0;
      div_ctrl.divisor = DIVISOR_W'(DIVISOR_W'(hz_clamp) * DIVISOR_W'(PRESCALE));

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               event_in = 1'b0;
               case (cmd_type'(req_channel.cmd))
                  CMD_TICK: begin
                     rsp_valid_in = 1'b1;
                     if (running_ff) begin
                        if ({1'b0, prescale_ff} + 1'b1 >= PRESCALE_END) begin
                           prescale_in = '0;
                           period_in   = period_next;
                           if (period_next == '0) begin
                              event_in = 1'b1;
                              pulse_in = !pulse_ff;
                              sent_in  = sent_next;
                              if (sent_next >= target_ff) begin
                                 running_in = 1'b0;
                                 pulse_in   = 1'b1;
                              end
                           end
                        end else begin
                           prescale_in = prescale_ff + 1'b1;
                        end
                     end
                  end
                  CMD_START: begin
                     rsp_valid_in = 1'b1;
                     if (req_channel.steps != '0) begin
                        pulse_in    = 1'b1;
                        dir_in      = req_channel.direction;
                        sent_in     = '0;
                        target_in   = req_channel.steps;
                        prescale_in = '0;
                        period_in   = '0;
                        running_in  = 1'b1;
                     end
                  end
                  CMD_STOP: begin
                     rsp_valid_in = 1'b1;
                     running_in   = 1'b0;
                     pulse_in     = 1'b1;
                  end
                  CMD_SET_FREQ: begin
                     div_ctrl.start = 1'b1;
                     state_in       = ST_DIVIDE;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            // the status slot drained before the divide began
            if (div_stat.done) begin
               reload_in    = reload_q;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b0;
         sent_ff      <= '0;
         target_ff    <= '0;
         dir_ff       <= 1'b0;
         pulse_ff     <= 1'b1;
         prescale_ff  <= '0;
         period_ff    <= '0;
         reload_ff    <= DEFAULT_RELOAD;
         rsp_valid_ff <= 1'b0;
         event_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         sent_ff      <= sent_in;
         target_ff    <= target_in;
         dir_ff       <= dir_in;
         pulse_ff     <= pulse_in;
         prescale_ff  <= prescale_in;
         period_ff    <= period_in;
         reload_ff    <= reload_in;
         rsp_valid_ff <= rsp_valid_in;
         event_ff     <= event_in;
      end
   end

   // drive the status word
   assign rsp_channel.valid       = rsp_valid_ff;
   assign rsp_channel.pulse_level = pulse_ff;
   assign rsp_channel.dir_level   = dir_ff;
   assign rsp_channel.busy_res    = running_ff;
   assign rsp_channel.step_event  = event_ff;
   assign rsp_channel.steps_done  = sent_ff;

endmodule
